[hdl/bfzs_pkg.sv]
// ----------------------------------------------------------------------------
// bfzs_pkg
// Shared types and constants of the bitmap first-zero search block.
// ----------------------------------------------------------------------------
package bfzs_pkg;

    // Default number of bytes held in the allocation map.
    localparam int MAP_BYTES_DEF = 64;

    localparam int BYTE_W  = 8;
    localparam int BIDX_W  = 6;   // byte index of a write transaction
    localparam int START_W = 10;  // start bit of a search transaction
    localparam int IDX_W   = START_W - 3;  // byte position reachable by a search
    localparam int BIT_W   = 9;   // reported bit index
    localparam int STAT_W  = 2;

    // Configuration port.
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic [APB_AW-1:0] ADDR_SCAN_LEN = 3'd0;
    localparam logic [IDX_W-1:0]  SCAN_LEN_RST  = 7'd64;

    // Transaction kinds.
    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_SEARCH = 1'b1;

    // Result status codes.
    localparam logic [STAT_W-1:0] STAT_FOUND  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NONE   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_BEYOND = 2'd2;

    typedef struct packed {
        logic               kind;
        logic [BIDX_W-1:0]  byte_index;
        logic [BYTE_W-1:0]  byte_value;
        logic [START_W-1:0] from_bit;
    } t_bfzs_in;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [BIT_W-1:0]  bit_index;
    } t_bfzs_out;

endpackage

[hdl/bfzs_map_ram.sv]
// ----------------------------------------------------------------------------
// bfzs_map_ram
// Single-port-write, single-port-read map memory with a registered read.
// ----------------------------------------------------------------------------
module bfzs_map_ram #(
    parameter int DEPTH = bfzs_pkg::MAP_BYTES_DEF,
    parameter int AW    = 6
) (
    input  logic                      i_clk,
    input  logic                      i_wr_en,
    input  logic [AW-1:0]             i_wr_addr,
    input  logic [bfzs_pkg::BYTE_W-1:0] i_wr_data,
    input  logic [AW-1:0]             i_rd_addr,
    output logic [bfzs_pkg::BYTE_W-1:0] o_rd_data
);
    import bfzs_pkg::*;

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[hdl/bitmap_first_zero_search.sv]
// ----------------------------------------------------------------------------
// bitmap_first_zero_search
// Allocation bitmap with a search for the lowest clear bit at or after a
// given start bit.
// ----------------------------------------------------------------------------
// After reset the block clears its map memory, one byte per cycle;
// input transactions are stalled during that pass, while configuration
// writes are taken as usual. A write transaction stores one map byte and
// produces no result. A search transaction reads map bytes one byte per
// cycle through the single read port of the map memory, from the start
// byte up to the first byte with a clear bit or the end of the map, and
// then passes its result on to the output register; a start beyond the
// map is reported without reading the map. The block works on one search
// at a time, but it accepts the next transaction while a finished result
// still waits in the output register.
// ----------------------------------------------------------------------------
module bitmap_first_zero_search #(
    parameter int MAP_BYTES = bfzs_pkg::MAP_BYTES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Input transactions.
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  bfzs_pkg::t_bfzs_in           i_in_data,
    // Result transactions.
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output bfzs_pkg::t_bfzs_out          o_out_data,
    // Configuration port.
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bfzs_pkg::APB_AW-1:0]  paddr,
    input  logic [bfzs_pkg::APB_DW-1:0]  pwdata,
    output logic [bfzs_pkg::APB_DW-1:0]  prdata,
    output logic                         pready
);
    import bfzs_pkg::*;

    // Address width of the map memory.
    localparam int AW = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
    // Largest map size a search can use: the memory depth or the largest
    // value of the size register, whichever is smaller.
    localparam logic [IDX_W-1:0] SIZE_CAP =
        IDX_W'((MAP_BYTES < (2 ** IDX_W) - 1) ? MAP_BYTES : (2 ** IDX_W) - 1);
    localparam logic [AW-1:0] CLR_LAST = AW'(MAP_BYTES - 1);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_SCAN  = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    // Position of the lowest clear bit of a byte that is not all ones.
    function automatic logic [2:0] lowest_clear(input logic [BYTE_W-1:0] d);
        logic [2:0] p;
        p = 3'd0;
        for (int k = BYTE_W - 1; k >= 0; k--) begin
            if (!d[k]) begin
                p = 3'(k);
            end
        end
        return p;
    endfunction

    t_state            r_state, n_state;
    logic [AW-1:0]     r_clr_addr;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [BYTE_W-1:0] r_mask, n_mask;
    t_bfzs_out         r_res, n_res;
    logic              r_out_valid;
    t_bfzs_out         r_out_data;
    logic [IDX_W-1:0]  r_scan_len;

    logic              in_acc;
    logic              out_load;
    logic              cfg_wr;
    logic [IDX_W-1:0]  eff_size;
    logic [IDX_W-1:0]  start_byte;
    logic [2:0]        start_pos;
    logic [BYTE_W-1:0] scan_byte;
    logic              scan_hit;
    logic [IDX_W-1:0]  next_idx;
    logic [IDX_W-1:0]  rd_idx;

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [BYTE_W-1:0] wr_data;
    logic [BYTE_W-1:0] rd_data;

    // The map memory. Writes and the clearing pass happen only in the idle
    // and clear states, and reads are used only while scanning; a used read
    // never meets a write to the same byte, so no forwarding is needed.
    bfzs_map_ram #(
        .DEPTH (MAP_BYTES),
        .AW    (AW)
    ) u_map_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (AW'(rd_idx)),
        .o_rd_data (rd_data)
    );

    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign out_load = !r_out_valid || !i_out_stall;
    assign cfg_wr   = psel && penable && pwrite;

    // A size above the memory depth is saturated; a size of zero makes every
    // search report a start beyond the map.
    assign eff_size   = (r_scan_len > SIZE_CAP) ? SIZE_CAP : r_scan_len;
    assign start_byte = i_in_data.from_bit[START_W-1:3];
    assign start_pos  = i_in_data.from_bit[2:0];

    // Bits below the start position of the first byte count as used.
    assign scan_byte = rd_data | r_mask;
    assign scan_hit  = (scan_byte != {BYTE_W{1'b1}});
    assign next_idx  = r_idx + 1'b1;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_mask  = r_mask;
        n_res   = r_res;
        rd_idx  = r_idx;
        wr_en   = 1'b0;
        wr_addr = r_clr_addr;
        wr_data = '0;
        unique case (r_state)
            S_CLEAR: begin
                wr_en = 1'b1;
                if (r_clr_addr == CLR_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in_data.kind == KIND_WRITE) begin
                        // Bytes past the end of the memory are dropped.
                        wr_en   = (int'(i_in_data.byte_index) < MAP_BYTES);
                        wr_addr = AW'(i_in_data.byte_index);
                        wr_data = i_in_data.byte_value;
                    end else if ((eff_size == '0) || (start_byte >= eff_size)) begin
                        n_res.status    = STAT_BEYOND;
                        n_res.bit_index = '0;
                        n_state         = S_DONE;
                    end else begin
                        rd_idx  = start_byte;
                        n_idx   = start_byte;
                        n_mask  = ~({BYTE_W{1'b1}} << start_pos);
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (scan_hit) begin
                    n_res.status    = STAT_FOUND;
                    n_res.bit_index = BIT_W'({r_idx, lowest_clear(scan_byte)});
                    n_state         = S_DONE;
                end else if (next_idx >= eff_size) begin
                    n_res.status    = STAT_NONE;
                    n_res.bit_index = '0;
                    n_state         = S_DONE;
                end else begin
                    // Later bytes are taken whole.
                    rd_idx = next_idx;
                    n_idx  = next_idx;
                    n_mask = '0;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
            r_scan_len  <= SCAN_LEN_RST;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if ((r_state == S_DONE) && out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (cfg_wr && (paddr == ADDR_SCAN_LEN)) begin
                r_scan_len <= pwdata[IDX_W-1:0];
            end
        end
    end

    // Scan position, first-byte mask and results.
    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_mask <= n_mask;
        r_res  <= n_res;
        if ((r_state == S_DONE) && out_load) begin
            r_out_data <= r_res;
        end
    end

    // Register read-back.
    always_comb begin
        unique case (paddr)
            ADDR_SCAN_LEN: prdata = APB_DW'(r_scan_len);
            default:       prdata = '0;
        endcase
    end

    assign pready      = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

[hdl/bfzs_checker.sv]
// ----------------------------------------------------------------------------
// bfzs_checker
// Port-level assertions for the bitmap first-zero search block.
// ----------------------------------------------------------------------------
module bfzs_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         o_in_stall,
    input  bfzs_pkg::t_bfzs_in           i_in_data,
    input  logic                         o_out_valid,
    input  logic                         i_out_stall,
    input  bfzs_pkg::t_bfzs_out          o_out_data
);
    import bfzs_pkg::*;

    // A result that is not a hit carries a zero bit index.
    a_idx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status != STAT_FOUND)) |->
            (o_out_data.bit_index == '0))
        else $error("non-hit result with a nonzero bit index");

    // The map is being cleared right after reset: no input, no result.
    a_clear_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> (o_in_stall && !o_out_valid))
        else $error("block active during the clearing pass");

    // A search occupies the block for at least the following cycle.
    a_search_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_in_data.kind == KIND_SEARCH)) |=>
            o_in_stall)
        else $error("search transaction did not occupy the block");

    // A map write finishes at once and leaves the block ready.
    a_write_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_in_data.kind == KIND_WRITE)) |=>
            !o_in_stall)
        else $error("map write left the block busy");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");

endmodule

bind bitmap_first_zero_search bfzs_checker u_bfzs_checker (.*);
